// ===== rtl/mdfc_pkg.sv =====
// Shared types, constants and helper functions of the depth-first maze carver.
package mdfc_pkg;

  localparam int GRID_SIDE   = 64;
  localparam int STACK_DEPTH = 1024;

  localparam int COORD_W    = $clog2(GRID_SIDE);
  localparam int VIS_ADDR_W = 2 * COORD_W;
  localparam int VIS_DEPTH  = 1 << VIS_ADDR_W;
  localparam int EPOCH_W    = 8;
  localparam int SP_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W      = COORD_W + 8;

  localparam int OP_W       = 1;
  localparam int RAND_W     = 8;
  localparam int OUT_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int NEXT_W     = 3;

  localparam logic [OP_W-1:0] OP_START = 1'b0;
  localparam logic [OP_W-1:0] OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INNER_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COLS = 1'b1;

  localparam logic [CFG_DATA_W-1:0] INNER_RESET = 6'd15;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef logic [3:0][1:0] dirs_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    dirs_t              dirs;
    logic [NEXT_W-1:0]  nxt;
  } frame_t;

  typedef struct packed {
    logic                  new_maze;
    logic                  wr;
    logic                  rd;
    logic [VIS_ADDR_W-1:0] addr;
  } vis_cmd_t;

  function automatic dirs_t shuffle_dirs(input logic [RAND_W-1:0] bits);
    dirs_t      d;
    logic [1:0] k;
    logic [1:0] t;
    for (int i = 0; i < 4; i++) begin
      d[i] = 2'(i);
    end
    for (int i = 0; i < 4; i++) begin
      k    = bits[2*i +: 2];
      t    = d[k];
      d[k] = d[i];
      d[i] = t;
    end
    return d;
  endfunction

  function automatic logic [VIS_ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col);
    return {row, col};
  endfunction

endpackage

// ===== rtl/mdfc_ifs.sv =====
// Handshake channel interfaces of the depth-first maze carver.
interface mdfc_req_if import mdfc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [RAND_W-1:0] random_bits;
  modport source(output valid, operation, random_bits, input ready);
  modport sink(input valid, operation, random_bits, output ready);
endinterface

interface mdfc_res_if import mdfc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cell_row;
  logic [OUT_W-1:0] cell_col;
  logic             last_of_step;
  logic             finished;
  modport source(output valid, cell_row, cell_col, last_of_step, finished, input ready);
  modport sink(input valid, cell_row, cell_col, last_of_step, finished, output ready);
endinterface

interface mdfc_cfg_if import mdfc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/mdfc_visit_map.sv =====
// Visited-cell memory with epoch marks and a clearing sweep after reset and when the epoch runs out.
module mdfc_visit_map import mdfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  vis_cmd_t cmd,
  output logic     busy,
  output logic     open
);

  logic [EPOCH_W-1:0]    mem [VIS_DEPTH];
  logic [EPOCH_W-1:0]    epoch;
  logic [EPOCH_W-1:0]    rdata;
  logic [VIS_ADDR_W-1:0] clr_cnt;
  logic                  clearing;
  logic                  pend_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      pend_new <= 1'b0;
      clr_cnt  <= '0;
      epoch    <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == {VIS_ADDR_W{1'b1}}) begin
        clearing <= 1'b0;
        pend_new <= 1'b0;
        epoch    <= pend_new ? EPOCH_W'(1) : '0;
      end
    end else if (cmd.new_maze) begin
      if (epoch == {EPOCH_W{1'b1}}) begin
        clearing <= 1'b1;
        pend_new <= 1'b1;
        clr_cnt  <= '0;
      end else begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.wr) begin
      mem[cmd.addr] <= epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[cmd.addr];
    end
  end

  assign busy = clearing;
  assign open = (rdata == epoch);

endmodule

// ===== rtl/maze_depth_first_carver.sv =====
// Top level of the depth-first maze carver: sequencer, frame stack and result register.
//
//  channel  role    word
//  cfg      sink    index, data (inner_rows, inner_cols)
//  req      sink    operation, random_bits
//  res      source  cell_row, cell_col, last_of_step, finished
//
// A start passes through S_START_A and S_START_B; a step reads the top frame from the stack
// memory in S_TOP, tests one direction per S_PROBE with a visited-memory probe in S_CHECK
// for each in-bounds one, then carves in S_CARVE_A and S_CARVE_B or pops. After reset, and on
// the 256th start and every 255th start after it, the visited memory's 4096 cells are swept
// while req.ready is low. A full result register stalls the sequencer only when it must emit.
module maze_depth_first_carver import mdfc_pkg::*; (
  input logic        clk,
  input logic        rst,
  mdfc_cfg_if.sink   cfg,
  mdfc_req_if.sink   req,
  mdfc_res_if.source res
);

  typedef enum logic [3:0] {
    S_IDLE, S_START_A, S_START_B, S_EMPTY, S_TOP, S_PROBE, S_CHECK, S_CARVE_A, S_CARVE_B
  } state_t;

  state_t                  state;
  logic [CFG_DATA_W-1:0]   inner_rows;
  logic [CFG_DATA_W-1:0]   inner_cols;
  logic [DEPTH_W-1:0]      depth;
  dirs_t                   dirs;
  logic [COORD_W-1:0]      frow;
  logic [COORD_W-1:0]      fcol;
  dirs_t                   fdir;
  logic [NEXT_W-1:0]       fnext;
  logic [COORD_W-1:0]      cand_r;
  logic [COORD_W-1:0]      cand_c;
  logic [COORD_W-1:0]      wall_r;
  logic [COORD_W-1:0]      wall_c;
  logic                    res_valid;
  logic [OUT_W-1:0]        res_row;
  logic [OUT_W-1:0]        res_col;
  logic                    res_last;
  logic                    res_fin;

  frame_t                  stack_mem [STACK_DEPTH];
  frame_t                  st_rdata;
  frame_t                  st_wdata;
  logic                    st_we;
  logic                    st_re;
  logic [SP_W-1:0]         st_waddr;
  logic [SP_W-1:0]         top_addr;

  vis_cmd_t                vcmd;
  logic                    vis_busy;
  logic                    vis_open;

  logic                    can_emit;
  logic                    emit;
  logic [COORD_W-1:0]      em_row;
  logic [COORD_W-1:0]      em_col;
  logic                    em_last;
  logic                    em_fin;
  logic                    req_ready;
  logic signed [CMP_W-1:0] base_r;
  logic signed [CMP_W-1:0] base_c;
  logic signed [CMP_W-1:0] r2;
  logic signed [CMP_W-1:0] c2;
  logic signed [CMP_W-1:0] rw;
  logic signed [CMP_W-1:0] cw;
  logic signed [CMP_W-1:0] lim_r;
  logic signed [CMP_W-1:0] lim_c;
  logic signed [CMP_W-1:0] side;
  logic signed [CMP_W-1:0] rows_n;
  logic signed [CMP_W-1:0] cols_n;
  logic                    in_frame;

  mdfc_visit_map u_visit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (vcmd),
    .busy (vis_busy),
    .open (vis_open)
  );

  assign cfg.ready    = 1'b1;
  assign req.ready    = req_ready;
  assign res.valid    = res_valid;
  assign res.cell_row = res_row;
  assign res.cell_col = res_col;
  assign res.last_of_step = res_last;
  assign res.finished = res_fin;

  assign can_emit = !res_valid || res.ready;
  assign top_addr = SP_W'(depth - 1'b1);

  // Bounds and candidate neighbour of the current direction.
  always_comb begin
    side   = CMP_W'(GRID_SIDE);
    rows_n = CMP_W'(inner_rows) + CMP_W'(2);
    cols_n = CMP_W'(inner_cols) + CMP_W'(2);
    lim_r  = ((rows_n > side) ? side : rows_n) - CMP_W'(1);
    lim_c  = ((cols_n > side) ? side : cols_n) - CMP_W'(1);
    base_r = CMP_W'(frow);
    base_c = CMP_W'(fcol);
    r2 = base_r;
    c2 = base_c;
    rw = base_r;
    cw = base_c;
    case (fdir[fnext[1:0]])
      DIR_UP: begin
        r2 = base_r - CMP_W'(2);
        rw = base_r - CMP_W'(1);
      end
      DIR_RIGHT: begin
        c2 = base_c + CMP_W'(2);
        cw = base_c + CMP_W'(1);
      end
      DIR_DOWN: begin
        r2 = base_r + CMP_W'(2);
        rw = base_r + CMP_W'(1);
      end
      default: begin
        c2 = base_c - CMP_W'(2);
        cw = base_c - CMP_W'(1);
      end
    endcase
    in_frame = (r2 >= CMP_W'(1)) && (r2 < lim_r) && (c2 >= CMP_W'(1)) && (c2 < lim_c);
  end

  always_comb begin
    req_ready = 1'b0;
    vcmd      = '0;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_waddr  = top_addr;
    st_wdata  = '{row: frow, col: fcol, dirs: fdir, nxt: fnext};
    emit      = 1'b0;
    em_row    = '0;
    em_col    = '0;
    em_last   = 1'b0;
    em_fin    = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !vis_busy;
        if (req.valid && !vis_busy) begin
          if (req.operation == OP_START) begin
            vcmd.new_maze = 1'b1;
          end else if (depth != '0) begin
            st_re = 1'b1;
          end
        end
      end
      S_START_A: begin
        if (!vis_busy && can_emit) begin
          vcmd.wr   = 1'b1;
          vcmd.addr = cell_addr(COORD_W'(0), COORD_W'(1));
          emit      = 1'b1;
          em_col    = COORD_W'(1);
        end
      end
      S_START_B: begin
        if (can_emit) begin
          vcmd.wr   = 1'b1;
          vcmd.addr = cell_addr(COORD_W'(1), COORD_W'(1));
          emit      = 1'b1;
          em_row    = COORD_W'(1);
          em_col    = COORD_W'(1);
          em_last   = 1'b1;
          st_we     = 1'b1;
          st_waddr  = '0;
          st_wdata  = '{row: COORD_W'(1), col: COORD_W'(1), dirs: dirs, nxt: '0};
        end
      end
      S_EMPTY: begin
        if (can_emit) begin
          emit    = 1'b1;
          em_last = 1'b1;
          em_fin  = 1'b1;
        end
      end
      S_TOP: begin
      end
      S_PROBE: begin
        if (!fnext[2] && in_frame) begin
          vcmd.rd   = 1'b1;
          vcmd.addr = cell_addr(COORD_W'(r2), COORD_W'(c2));
        end
      end
      S_CHECK: begin
      end
      S_CARVE_A: begin
        if (can_emit) begin
          vcmd.wr   = 1'b1;
          vcmd.addr = cell_addr(wall_r, wall_c);
          emit      = 1'b1;
          em_row    = wall_r;
          em_col    = wall_c;
          st_we     = 1'b1;
        end
      end
      S_CARVE_B: begin
        if (can_emit) begin
          vcmd.wr   = 1'b1;
          vcmd.addr = cell_addr(cand_r, cand_c);
          emit      = 1'b1;
          em_row    = cand_r;
          em_col    = cand_c;
          em_last   = 1'b1;
          st_we     = (depth < DEPTH_W'(STACK_DEPTH));
          st_waddr  = SP_W'(depth);
          st_wdata  = '{row: cand_r, col: cand_c, dirs: dirs, nxt: '0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata <= stack_mem[top_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth      <= '0;
      inner_rows <= INNER_RESET;
      inner_cols <= INNER_RESET;
      res_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_INNER_ROWS: inner_rows <= cfg.data;
          REG_INNER_COLS: inner_cols <= cfg.data;
          default: begin
          end
        endcase
      end
      if (emit) begin
        res_valid <= 1'b1;
        res_row   <= OUT_W'(em_row);
        res_col   <= OUT_W'(em_col);
        res_last  <= em_last;
        res_fin   <= em_fin;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req_ready) begin
            dirs <= shuffle_dirs(req.random_bits);
            if (req.operation == OP_START) begin
              depth <= '0;
              state <= S_START_A;
            end else if (depth == '0) begin
              state <= S_EMPTY;
            end else begin
              state <= S_TOP;
            end
          end
        end
        S_START_A: begin
          if (emit) begin
            state <= S_START_B;
          end
        end
        S_START_B: begin
          if (emit) begin
            depth <= DEPTH_W'(1);
            state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        S_TOP: begin
          frow  <= st_rdata.row;
          fcol  <= st_rdata.col;
          fdir  <= st_rdata.dirs;
          fnext <= st_rdata.nxt;
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (fnext[2]) begin
            depth <= depth - 1'b1;
            state <= S_IDLE;
          end else begin
            fnext  <= fnext + 1'b1;
            cand_r <= COORD_W'(r2);
            cand_c <= COORD_W'(c2);
            wall_r <= COORD_W'(rw);
            wall_c <= COORD_W'(cw);
            if (in_frame) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          state <= vis_open ? S_PROBE : S_CARVE_A;
        end
        S_CARVE_A: begin
          if (emit) begin
            state <= S_CARVE_B;
          end
        end
        S_CARVE_B: begin
          if (emit) begin
            if (st_we) begin
              depth <= depth + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("Frame stack depth beyond its capacity.");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (state == S_IDLE) && !vis_busy)
    else $error("Word taken while the sequencer is busy.");

  a_probe_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE || state == S_CHECK || state == S_CARVE_A) |-> depth != '0)
    else $error("Search running on an empty stack.");

  a_check_from_probe: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(state) == S_PROBE && !$past(fnext[2]))
    else $error("Visited check without a probe before it.");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> can_emit)
    else $error("Result register overwritten before it was taken.");
`endif

endmodule
